// ----- design/pps_pkg.sv -----
// Package for the preemptive priority scheduler: task record, widths, states.
// No dependencies.
package pps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // action codes of an input word
   localparam logic ACT_ARRIVE = 1'b0;
   localparam logic ACT_TICK   = 1'b1;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [31:0] arrive;
      logic [31:0] start;
      logic        started;
      logic [16:0] run;
   } task_type;

   typedef struct packed {
      logic        busy_res;
      logic [7:0]  running_id;
      logic        done_valid;
      logic [7:0]  done_id;
      logic [31:0] finish_time;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic [31:0] response;
      logic        queue_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_WR,
      ST_POP_RD,
      ST_POP_SH,
      ST_POP_MV,
      ST_OUT
   } state_type;

   // Control word from sequencer to queue store
   typedef struct packed {
      logic              wr_en;
      logic [QIDX_W-1:0] wr_addr;
      logic [QIDX_W-1:0] rd_addr;
   } qctl_type;

   // a goes strictly before b
   function automatic logic goes_before(task_type a, task_type b);
      if (a.prio != b.prio) return a.prio < b.prio;
      return a.id < b.id;
   endfunction

endpackage

// ----- design/pps_if.sv -----
// Valid/ready channel carrying one word of a given type.
// Depends on pps_pkg.
interface pps_req_if import pps_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  task_id;
   logic [7:0]  task_priority;
   logic [15:0] burst_length;
   modport source (output valid, action, task_id, task_priority, burst_length,
                   input ready);
   modport sink   (input valid, action, task_id, task_priority, burst_length,
                   output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- design/pps_queue_ram.sv -----
// Ready queue store: one write port, one registered read port.
// Depends on pps_pkg.
module pps_queue_ram import pps_pkg::*; (
   input  logic     clock,
   input  qctl_type ctl,
   input  task_type wr_data,
   output task_type rd_data
);
   task_type mem [QUEUE_DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem[ctl.wr_addr] <= wr_data;
      rd_data <= mem[ctl.rd_addr];
   end
endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler over a sorted ready queue.
//
// Channels: req (valid/ready) carries action, task_id, task_priority and
// burst_length. action 0 inserts a task stamped with the current time and
// returns no word. action 1 is a tick and returns one rsp word: which task
// ran, any retired task with its finish, turnaround, waiting and response
// times, and the sticky queue overflow flag.
// One item at a time; the single registered queue read port and the one
// task compare serialize the work. An arrival to a full queue is dropped
// and sets the overflow flag, one to an empty queue is written at once, and
// otherwise entries are read from the tail, compared and shifted up one
// slot until the task's slot is found. A tick with an empty queue, or whose
// head is not taken, goes straight to its word; else the head is popped,
// the entries behind it shift down, and a preempted task is reinserted.
// The tick word sits in an output register; req is not ready while it waits,
// so a stalled receiver holds the block. Reset clears the queue count,
// running task, time and overflow flag; queue contents need no clearing.
module preemptive_priority_scheduler import pps_pkg::*; (
   input  logic clock,
   input  logic reset,
   pps_req_if.sink   req,
   pps_rsp_if.source rsp
);
   state_type         state_ff, state_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] idx_ff, idx_in;
   logic              cur_valid_ff, cur_valid_in;
   task_type          cur_ff, cur_in;
   task_type          ins_ff, ins_in;      // task being inserted
   task_type          head_ff, head_in;    // popped head
   logic              tick_ff, tick_in;    // insert is part of a tick (preempt)
   logic [31:0]       time_ff, time_in;
   logic              ovf_ff, ovf_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   qctl_type          ctl;
   task_type          wr_data, rd_data;
   logic              accept, retire, ins_ahead, take_head, shift_more;

   pps_queue_ram u_ram (.clock, .ctl, .wr_data, .rd_data);

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   assign accept     = req.valid && req.ready;
   assign retire     = cur_valid_ff && (cur_ff.run >= {1'b0, cur_ff.burst});
   // compares against the word just read from the queue
   assign ins_ahead  = goes_before(ins_ff, rd_data);
   assign take_head  = !cur_valid_ff || (rd_data.prio < cur_ff.prio);
   assign shift_more = idx_ff < count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            if (req.action == ACT_ARRIVE) begin
               if (count_ff == QCNT_W'(QUEUE_DEPTH)) state_in = ST_IDLE;
               else if (count_ff == '0) state_in = ST_INS_WR;
               else state_in = ST_INS_RD;
            end else begin
               state_in = (count_ff != '0) ? ST_POP_RD : ST_OUT;
            end
         end
         ST_INS_RD:  state_in = ST_INS_CMP;
         ST_INS_CMP: state_in = (ins_ahead && idx_ff > QCNT_W'(1)) ? ST_INS_RD : ST_INS_WR;
         ST_INS_WR:  state_in = tick_ff ? ST_OUT : ST_IDLE;
         ST_POP_RD:  state_in = take_head ? ST_POP_SH : ST_OUT;
         ST_POP_SH: begin
            if (shift_more) state_in = ST_POP_MV;
            else if (!cur_valid_ff) state_in = ST_OUT;
            else if (count_ff == QCNT_W'(1)) state_in = ST_INS_WR;
            else state_in = ST_INS_RD;
         end
         ST_POP_MV:  state_in = ST_POP_SH;
         ST_OUT:     state_in = ST_IDLE;
      endcase
   end

   // datapath and queue control
   always_comb begin
      count_in = count_ff; idx_in = idx_ff; cur_valid_in = cur_valid_ff;
      cur_in = cur_ff; ins_in = ins_ff; head_in = head_ff; tick_in = tick_ff;
      time_in = time_ff; ovf_in = ovf_ff; out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      ctl = '0; wr_data = ins_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) begin
            tick_in = (req.action == ACT_TICK);
            if (req.action == ACT_ARRIVE) begin
               ins_in = '{id: req.task_id, prio: req.task_priority,
                          burst: req.burst_length, arrive: time_ff,
                          start: '0, started: 1'b0, run: '0};
               idx_in = count_ff;
               if (count_ff == QCNT_W'(QUEUE_DEPTH)) ovf_in = 1'b1;
            end else begin
               out_in = '0;
               if (retire) begin
                  out_in.done_valid  = 1'b1;
                  out_in.done_id     = cur_ff.id;
                  out_in.finish_time = time_ff;
                  out_in.turnaround  = time_ff - cur_ff.arrive;
                  out_in.waiting     = time_ff - cur_ff.arrive - 32'(cur_ff.burst);
                  out_in.response    = cur_ff.start - cur_ff.arrive;
                  cur_valid_in = 1'b0;
               end
               // head read for the preempt check
               ctl.rd_addr = '0;
            end
         end
         ST_INS_RD: ctl.rd_addr = QIDX_W'(idx_ff - 1'b1);
         ST_INS_CMP: begin
            // shift the compared entry up one slot
            if (ins_ahead) begin
               ctl.wr_en = 1'b1; ctl.wr_addr = QIDX_W'(idx_ff);
               wr_data = rd_data;
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_INS_WR: begin
            ctl.wr_en = 1'b1; ctl.wr_addr = QIDX_W'(idx_ff);
            wr_data = ins_ff;
            count_in = count_ff + 1'b1;
         end
         ST_POP_RD: begin
            head_in = rd_data;
            idx_in = QCNT_W'(1);
         end
         ST_POP_SH: begin
            if (shift_more) begin
               ctl.rd_addr = QIDX_W'(idx_ff);
            end else begin
               // pop complete: head becomes the running task
               count_in = count_ff - 1'b1;
               cur_valid_in = 1'b1;
               cur_in = head_ff;
               if (!head_ff.started) begin
                  cur_in.started = 1'b1; cur_in.start = time_ff;
               end
               if (cur_valid_ff) begin
                  ins_in = cur_ff;
                  idx_in = count_ff - 1'b1;
               end
            end
         end
         ST_POP_MV: begin
            ctl.wr_en = 1'b1; ctl.wr_addr = QIDX_W'(idx_ff - 1'b1);
            wr_data = rd_data;
            idx_in = idx_ff + 1'b1;
         end
         ST_OUT: begin
            if (cur_valid_ff) begin
               cur_in.run = cur_ff.run + 1'b1;
               out_in.busy_res = 1'b1;
               out_in.running_id = cur_ff.id;
            end
            out_in.queue_overflow = ovf_ff;
            out_valid_in = 1'b1;
            time_in = time_ff + 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; cur_valid_ff <= 1'b0;
         cur_ff <= '0; time_ff <= '0; ovf_ff <= 1'b0; out_valid_ff <= 1'b0;
         idx_ff <= '0; tick_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; cur_valid_ff <= cur_valid_in; cur_ff <= cur_in;
         time_ff <= time_in; ovf_ff <= ovf_in; out_valid_ff <= out_valid_in;
         idx_ff <= idx_in; tick_ff <= tick_in;
      end
      ins_ff <= ins_in; head_ff <= head_in; out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count past depth");
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !req.ready) else $error("ready while word waits");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> out_valid_ff) else $error("tick word missing");
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
      else $error("waiting word changed");
endmodule

// ----- tb/sv/pps_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the preemptive priority scheduler testbench: a predictor of
// the ready queue and tick words. Depends on pps_pkg.
package pps_tb_pkg;
   import pps_pkg::*;

   typedef struct {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic [31:0] arrive;
      logic [31:0] start;
      logic        started;
      logic [16:0] run;
   } job_rec;

   class sched_scoreboard;
      job_rec      ready_q[$];
      logic        running;
      job_rec      cur;
      logic [31:0] now;
      logic        ovf;
      rsp_type     tick_words[$];
      int          mismatches;
      int          ticks_checked;
      int          retired;
      int          ovf_seen;

      function new();
         ready_q = {};
         running = 1'b0;
         cur = '{default: '0};
         now = '0;
         ovf = 1'b0;
         mismatches = 0;
         ticks_checked = 0;
         retired = 0;
         ovf_seen = 0;
      endfunction

      function bit ahead(job_rec a, job_rec b);
         if (a.prio != b.prio) return a.prio < b.prio;
         return a.id < b.id;
      endfunction

      // sorted insert, stable for equal keys
      function void enqueue(job_rec j);
         int i;
         if (ready_q.size() >= QUEUE_DEPTH) begin
            ovf = 1'b1;
            return;
         end
         i = ready_q.size();
         while (i > 0 && ahead(j, ready_q[i-1])) i--;
         ready_q.insert(i, j);
      endfunction

      // note one accepted input word
      function void note_word(logic act, logic [7:0] id, logic [7:0] prio,
                              logic [15:0] burst);
         job_rec  j;
         rsp_type w;
         w = '0;
         if (act == ACT_ARRIVE) begin
            j = '{id: id, prio: prio, burst: burst, arrive: now, start: '0,
                  started: 1'b0, run: '0};
            enqueue(j);
            return;
         end
         if (running && cur.run >= {1'b0, cur.burst}) begin
            w.done_valid  = 1'b1;
            w.done_id     = cur.id;
            w.finish_time = now;
            w.turnaround  = now - cur.arrive;
            w.waiting     = w.turnaround - 32'(cur.burst);
            w.response    = cur.start - cur.arrive;
            running = 1'b0;
         end
         if (ready_q.size() > 0 && (!running || ready_q[0].prio < cur.prio)) begin
            j = ready_q.pop_front();
            if (running) enqueue(cur);
            cur = j;
            running = 1'b1;
            if (!cur.started) begin
               cur.started = 1'b1;
               cur.start = now;
            end
         end
         if (running) begin
            cur.run = cur.run + 17'd1;
            w.busy_res = 1'b1;
            w.running_id = cur.id;
         end
         now++;
         w.queue_overflow = ovf;
         tick_words.push_back(w);
      endfunction

      // compare one result word with the oldest prediction
      function void check_word(rsp_type got);
         rsp_type e;
         if (tick_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected rsp word %p", got);
            return;
         end
         e = tick_words.pop_front();
         ticks_checked++;
         if (e.done_valid) retired++;
         if (e.queue_overflow) ovf_seen++;
         if (got.busy_res !== e.busy_res || got.running_id !== e.running_id ||
             got.done_valid !== e.done_valid || got.done_id !== e.done_id ||
             got.finish_time !== e.finish_time || got.turnaround !== e.turnaround ||
             got.waiting !== e.waiting || got.response !== e.response ||
             got.queue_overflow !== e.queue_overflow) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: tick %0d mismatch\n  exp %p\n  got %p",
                        ticks_checked, e, got);
         end
      endfunction
   endclass
endpackage

// ----- tb/sv/tb_preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus and result checking.
// Depends on pps_pkg, pps_tb_pkg, the channel interfaces and the block.
module tb_preemptive_priority_scheduler;
   import pps_pkg::*;
   import pps_tb_pkg::*;

   logic clock;
   logic reset;
   pps_req_if req ();
   pps_rsp_if rsp ();
   sched_scoreboard sb;
   int   n_arrive;
   int   n_tick;

   preemptive_priority_scheduler dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Regression FAIL");
      $finish;
   end

   // send one word; waits out a random gap first, valid drops only for a gap
   task automatic send_word(logic act, logic [7:0] id, logic [7:0] prio,
                            logic [15:0] burst, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.action <= act;
      req.task_id <= id;
      req.task_priority <= prio;
      req.burst_length <= burst;
      do @(posedge clock); while (!req.ready);
      sb.note_word(act, id, prio, burst);
      if (act == ACT_ARRIVE) n_arrive++; else n_tick++;
   endtask

   task automatic tick(int n);
      repeat (n) send_word(ACT_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic arrive(logic [7:0] id, logic [7:0] prio, logic [15:0] burst);
      send_word(ACT_ARRIVE, id, prio, burst);
   endtask

   // stop sending and wait for every expected word
   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.tick_words.size() > 0);
   endtask

   // result side: random stall per word
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         sb.check_word(rsp.data);
      end
   end

   initial begin
      int k;
      int burst_cap;
      sb = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.action = ACT_TICK;
      req.task_id = '0;
      req.task_priority = '0;
      req.burst_length = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle tick, extremes, zero burst, ties, preemption
      tick(2);
      arrive(8'd255, 8'd255, 16'd0);
      arrive(8'd0, 8'd255, 16'd2);
      tick(3);
      arrive(8'd7, 8'd10, 16'd4);
      tick(1);
      arrive(8'd9, 8'd0, 16'd1);
      tick(8);
      arrive(8'hAA, 8'h55, 16'hFFFF);
      arrive(8'h55, 8'hAA, 16'h0001);
      tick(3);
      // fill queue past depth to raise overflow
      for (k = 0; k < QUEUE_DEPTH + 3; k++) arrive(k[7:0], 8'd200, 16'd1);
      tick(4);
      drain();

      // random mix of arrivals and ticks, pausing once at k == 600 to drain
      for (k = 0; k < 4000; k++) begin
         if (k == 600) drain();
         burst_cap = ($urandom_range(0, 20) == 0) ? 65535 : 6;
         if ($urandom_range(0, 9) < 4)
            arrive(8'($urandom),
                   8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom),
                   16'($urandom_range(0, burst_cap)));
         else
            tick(1);
         if (n_arrive + n_tick >= 1700 && k > 1700) break;
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d arrivals and %0d ticks; %0d retirements, %0d words with overflow set",
               n_arrive, n_tick, sb.retired, sb.ovf_seen);
      if (sb.mismatches == 0 && sb.tick_words.size() == 0) $display("Regression PASS");
      else begin
         $display("%0d mismatches, %0d words missing", sb.mismatches, sb.tick_words.size());
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
